// ===== rtl/core/string_literal_escape_decoder_macros.svh =====
// Assertion macros shared by the string literal escape decoder modules.
`ifndef STRING_LITERAL_ESCAPE_DECODER_MACROS_SVH
`define STRING_LITERAL_ESCAPE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define SLED_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sled assertion failed");
// When pre holds, post must hold at the next clock edge.
`define SLED_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("sled assertion failed");
`else
`define SLED_ASSERT(label, cond)
`define SLED_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/core/sled_pkg.sv =====
// Types, codes and constants of the string literal escape decoder.
package sled_pkg;

   // result kinds
   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // decode modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_OCTAL  = 2'd2;
   localparam logic [1:0] MODE_CR     = 2'd3;

   localparam int          LENGTH_WIDTH        = 12;
   localparam int          DEFAULT_COUNT_WIDTH = 12;
   localparam logic [11:0] DEFAULT_MAX_LENGTH  = 12'd2047;
   localparam logic [8:0]  OCTAL_MAX           = 9'd255;

   // source characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'd27;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DIGIT0 = 8'h30;
   localparam logic [7:0] CH_DIGIT7 = 8'h37;
   localparam logic [7:0] CH_DIGIT9 = 8'h39;

   // one result word
   typedef struct packed {
      logic [1:0]              kind;
      logic [7:0]              data;
      logic [LENGTH_WIDTH-1:0] length;
      logic                    last;
   } result_type;

   // escape decoder state apart from the character count
   typedef struct packed {
      logic [1:0] mode;
      logic [8:0] value;
      logic       stopped;
      logic [1:0] digits;
   } esc_state_type;

   localparam esc_state_type ESC_STATE_RESET = '{
      mode: MODE_NORMAL, value: 9'd0, stopped: 1'b0, digits: 2'd0};

   // single-letter escapes: {known, decoded character}
   function automatic logic [8:0] esc_lookup(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         8'h61:     r = {1'b1, 8'd7};    // a
         8'h62:     r = {1'b1, 8'd8};    // b
         8'h74:     r = {1'b1, 8'd9};    // t
         8'h6E:     r = {1'b1, 8'd10};   // n
         8'h76:     r = {1'b1, 8'd11};   // v
         8'h66:     r = {1'b1, 8'd12};   // f
         8'h72:     r = {1'b1, 8'd13};   // r
         8'h65:     r = {1'b1, CH_ESC};  // e
         CH_QUOTE:  r = {1'b1, CH_QUOTE};
         CH_APOS:   r = {1'b1, CH_APOS};
         CH_BSLASH: r = {1'b1, CH_BSLASH};
         default:   r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/sled_decode.sv =====
// Next-state and result logic for one source byte.
module sled_decode
   import sled_pkg::*;
#(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic [7:0]             in_byte,
   input  esc_state_type          state,
   input  logic [COUNT_WIDTH-1:0] char_count,
   input  logic [11:0]            max_length,
   output esc_state_type          next_state,
   output logic [COUNT_WIDTH-1:0] next_count,
   output result_type             res0,
   output result_type             res1,
   output logic [1:0]             res_num
);

   localparam int CMP_W = (COUNT_WIDTH > LENGTH_WIDTH) ? COUNT_WIDTH : LENGTH_WIDTH;

   logic [COUNT_WIDTH-1:0] cnt1, cnt2;
   logic [CMP_W-1:0]       cnt0_x, cnt1_x, cnt2_x, max_x;
   logic [11:0]            len0, len1, len2;
   logic                   over0, over1;
   logic                   is_digit, is_octal, b_quote, b_bslash, b_zero;
   logic [8:0]             esc_hit;
   logic [8:0]             dig_value;
   logic                   dig_stop;
   logic [1:0]             dig_count;
   logic [8:0]             fin_value;
   logic                   fin_err;

   // count arithmetic and limit checks
   assign cnt1   = char_count + 1'b1;
   assign cnt2   = char_count + 2'd2;
   assign cnt0_x = CMP_W'(char_count);
   assign cnt1_x = CMP_W'(cnt1);
   assign cnt2_x = CMP_W'(cnt2);
   assign max_x  = CMP_W'(max_length);
   assign len0   = cnt0_x[11:0];
   assign len1   = cnt1_x[11:0];
   assign len2   = cnt2_x[11:0];
   assign over0  = (cnt0_x >= max_x) || (char_count == '1);
   assign over1  = (cnt1_x >= max_x) || (cnt1 == '1);

   // byte classes
   assign is_digit = (in_byte >= CH_DIGIT0) && (in_byte <= CH_DIGIT9);
   assign is_octal = (in_byte >= CH_DIGIT0) && (in_byte <= CH_DIGIT7);
   assign b_quote  = (in_byte == CH_QUOTE);
   assign b_bslash = (in_byte == CH_BSLASH);
   assign b_zero   = (in_byte == CH_NUL);
   assign esc_hit  = esc_lookup(in_byte);

   // octal digit accumulation; 8 and 9 freeze the value
   assign dig_stop  = state.stopped || !is_octal;
   assign dig_value = dig_stop ? state.value : {state.value[5:0], in_byte[2:0]};
   assign dig_count = state.digits + 1'b1;

   // value the escape ends with: after this digit, or as it stood
   assign fin_value = is_digit ? dig_value : state.value;
   assign fin_err   = (fin_value > OCTAL_MAX) || (fin_value[7:0] == 8'd0) || over0;

   always_comb begin
      next_state = state;
      next_count = char_count;
      res0       = '0;
      res1       = '0;
      res_num    = 2'd0;
      case (state.mode)
         MODE_ESCAPE: begin
            next_state.mode = MODE_NORMAL;
            if (is_octal) begin
               next_state.mode    = MODE_OCTAL;
               next_state.value   = {6'd0, in_byte[2:0]};
               next_state.stopped = 1'b0;
               next_state.digits  = 2'd1;
            end else if (in_byte == CH_LF) begin
               // line continuation, nothing out
            end else if (in_byte == CH_CR) begin
               next_state.mode = MODE_CR;
            end else if (esc_hit[8] && !over0) begin
               res0       = '{kind: KIND_CHAR, data: esc_hit[7:0], length: len1, last: 1'b1};
               res_num    = 2'd1;
               next_count = cnt1;
            end else begin
               res0       = '{kind: KIND_ERROR, data: 8'd0, length: len0, last: 1'b1};
               res_num    = 2'd1;
               next_state = ESC_STATE_RESET;
               next_count = '0;
            end
         end
         MODE_OCTAL: begin
            if (is_digit && (dig_count != 2'd3)) begin
               // escape goes on
               next_state.value   = dig_value;
               next_state.stopped = dig_stop;
               next_state.digits  = dig_count;
            end else begin
               next_state = ESC_STATE_RESET;
               res_num    = 2'd1;
               if (fin_err) begin
                  res0       = '{kind: KIND_ERROR, data: 8'd0, length: len0, last: 1'b1};
                  next_count = '0;
               end else begin
                  res0       = '{kind: KIND_CHAR, data: fin_value[7:0], length: len1,
                                 last: 1'b1};
                  next_count = cnt1;
                  // a non-digit that ended the escape is decoded as a plain byte
                  if (!is_digit) begin
                     if (b_quote) begin
                        res1       = '{kind: KIND_END, data: 8'd0, length: len1, last: 1'b1};
                        res_num    = 2'd2;
                        next_count = '0;
                     end else if (b_bslash) begin
                        next_state.mode = MODE_ESCAPE;
                     end else if (b_zero || over1) begin
                        res1       = '{kind: KIND_ERROR, data: 8'd0, length: len1, last: 1'b1};
                        res_num    = 2'd2;
                        next_count = '0;
                     end else begin
                        res1       = '{kind: KIND_CHAR, data: in_byte, length: len2, last: 1'b1};
                        res_num    = 2'd2;
                        next_count = cnt2;
                     end
                     res0.last = (res_num == 2'd1);
                  end
               end
            end
         end
         default: begin
            // plain byte; after a CR continuation an LF is swallowed
            next_state.mode = MODE_NORMAL;
            if ((state.mode == MODE_CR) && (in_byte == CH_LF)) begin
               // swallowed
            end else if (b_quote) begin
               res0       = '{kind: KIND_END, data: 8'd0, length: len0, last: 1'b1};
               res_num    = 2'd1;
               next_state = ESC_STATE_RESET;
               next_count = '0;
            end else if (b_bslash) begin
               next_state.mode = MODE_ESCAPE;
            end else if (b_zero || over0) begin
               res0       = '{kind: KIND_ERROR, data: 8'd0, length: len0, last: 1'b1};
               res_num    = 2'd1;
               next_state = ESC_STATE_RESET;
               next_count = '0;
            end else begin
               res0       = '{kind: KIND_CHAR, data: in_byte, length: len1, last: 1'b1};
               res_num    = 2'd1;
               next_count = cnt1;
            end
         end
      endcase
   end

endmodule

// ===== rtl/core/sled_queue.sv =====
// Three-entry result queue taking up to two words per cycle while it has room.
`include "string_literal_escape_decoder_macros.svh"
module sled_queue
   import sled_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_num,
   input  result_type push0,
   input  result_type push1,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_word
);

   localparam int DEPTH = 3;

   result_type slot_ff [DEPTH];
   result_type slot_in [DEPTH];
   logic [1:0] count_ff, count_in;
   logic [1:0] level;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_word  = slot_ff[0];
   assign pop       = out_valid && out_ready;
   // two free entries after this cycle's pop
   assign room      = (count_ff < 2'd2) || ((count_ff == 2'd2) && out_ready);

   // shift out on pop, then append at the new level
   always_comb begin
      level = count_ff - {1'b0, pop};
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && (i < DEPTH - 1)) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if ((push_num != 2'd0) && (i == int'(level))) begin
            slot_in[i] = push0;
         end
         if ((push_num == 2'd2) && (i == int'(level) + 1)) begin
            slot_in[i] = push1;
         end
      end
      count_in = level + push_num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   `SLED_ASSERT(a_no_overflow, ({1'b0, count_ff} - {2'b0, pop} + {1'b0, push_num}) <= 3'd3)
   `SLED_ASSERT_NEXT(a_pop_drains, pop && (push_num == 2'd0), count_ff == $past(count_ff) - 2'd1)
   `SLED_ASSERT_NEXT(a_empty_stays, (count_ff == 2'd0) && (push_num == 2'd0), !out_valid)

endmodule

// ===== rtl/core/string_literal_escape_decoder.sv =====
// String literal escape decoder: one source byte per cycle in while req_ready is high, decoded words out.
// A result is registered in the result queue before it appears on rsp_.
// Throughput: one byte per cycle while each byte gives at most one word and rsp_ready is
// high; a byte that closes an octal escape and adds a character gives two words, and the
// single-word rsp_ port then sets the pace. A three-entry result queue parts the two sides.
// Reset (synchronous): normal mode, count zero, queue empty, max_length 2047.
`include "string_literal_escape_decoder_macros.svh"
module string_literal_escape_decoder
   import sled_pkg::*;
#(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [11:0] rsp_length,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);

   esc_state_type          state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [11:0]            max_length_ff;
   result_type             res0, res1, rsp_word;
   logic [1:0]             res_num;
   logic                   accept;

   assign accept = req_valid && req_ready;

   // byte decode
   sled_decode #(.COUNT_WIDTH(COUNT_WIDTH)) u_decode (
      .in_byte    (req_in_byte),
      .state      (state_ff),
      .char_count (count_ff),
      .max_length (max_length_ff),
      .next_state (state_in),
      .next_count (count_in),
      .res0       (res0),
      .res1       (res1),
      .res_num    (res_num)
   );

   // decoder state, advanced on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ESC_STATE_RESET;
         count_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= DEFAULT_MAX_LENGTH;
      end else if (csr_write_enable) begin
         max_length_ff <= csr_write_data;
      end
   end

   // result queue
   sled_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_num  (accept ? res_num : 2'd0),
      .push0     (res0),
      .push1     (res1),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

   assign rsp_kind     = rsp_word.kind;
   assign rsp_out_byte = rsp_word.data;
   assign rsp_length   = rsp_word.length;
   assign rsp_last     = rsp_word.last;

   `SLED_ASSERT(a_octal_digits, (state_ff.mode != MODE_OCTAL) || (state_ff.digits == 2'd1) || (state_ff.digits == 2'd2))
   `SLED_ASSERT_NEXT(a_end_restarts, accept && (res_num != 2'd0) && ((res_num == 2'd1 ? res0.kind : res1.kind) != KIND_CHAR), (count_ff == '0) && (state_ff.mode == MODE_NORMAL))
   `SLED_ASSERT(a_two_need_char, (res_num != 2'd2) || (res0.kind == KIND_CHAR))

endmodule

// ===== dv/string_literal_escape_decoder_tb.sv =====
// Testbench for the string literal escape decoder: directed and random strings checked against a predictor.
`timescale 1ns / 1ps
module string_literal_escape_decoder_tb
   import sled_pkg::*;
;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [11:0] rsp_length;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [11:0] csr_write_data = 12'd0;

   // source bytes waiting to be offered, decoded words still owed by the block
   logic [7:0]  pending_bytes[$];
   result_type  expected_words[$];
   result_type  step_words[$];

   int          bytes_queued = 0;
   int          bytes_accepted = 0;
   int          failures = 0;
   bit          req_taken = 1'b0;
   bit          idle_enable = 1'b0;
   bit          hold_wanted = 1'b0;
   bit          hold_taken = 1'b0;
   int          gap_left = 0;
   int          stall_left = 0;

   // decoder state mirrored for prediction
   logic [1:0]  scan_mode = MODE_NORMAL;
   logic [8:0]  oct_value = 9'd0;
   logic        oct_stopped = 1'b0;
   logic [1:0]  oct_digits = 2'd0;
   logic [11:0] char_count = 12'd0;
   logic [11:0] length_limit = DEFAULT_MAX_LENGTH;

   string_literal_escape_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_length       (rsp_length),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   task automatic put_word(input logic [1:0] kind, input logic [7:0] data);
      result_type w;
      w.kind   = kind;
      w.data   = data;
      w.length = char_count;
      w.last   = 1'b0;
      step_words.push_back(w);
   endtask

   task automatic restart_string();
      scan_mode   = MODE_NORMAL;
      oct_value   = 9'd0;
      oct_stopped = 1'b0;
      oct_digits  = 2'd0;
      char_count  = 12'd0;
   endtask

   task automatic raise_error();
      put_word(KIND_ERROR, CH_NUL);
      restart_string();
   endtask

   // zero bytes and over-length both end the string with an error
   task automatic add_char(input logic [7:0] c);
      if (c == CH_NUL || char_count >= length_limit || char_count == '1) begin
         raise_error();
      end else begin
         char_count = char_count + 12'd1;
         put_word(KIND_CHAR, c);
      end
   endtask

   task automatic plain_byte(input logic [7:0] b);
      if (b == CH_QUOTE) begin
         put_word(KIND_END, CH_NUL);
         restart_string();
      end else if (b == CH_BSLASH) begin
         scan_mode = MODE_ESCAPE;
      end else if (b == CH_NUL) begin
         raise_error();
      end else begin
         add_char(b);
      end
   endtask

   task automatic escape_byte(input logic [7:0] b);
      scan_mode = MODE_NORMAL;
      if (b >= CH_DIGIT0 && b <= CH_DIGIT7) begin
         scan_mode   = MODE_OCTAL;
         oct_value   = 9'(b - CH_DIGIT0);
         oct_stopped = 1'b0;
         oct_digits  = 2'd1;
      end else begin
         case (b)
            "a":       add_char(8'd7);
            "b":       add_char(8'd8);
            "t":       add_char(8'd9);
            "n":       add_char(8'd10);
            "v":       add_char(8'd11);
            "f":       add_char(8'd12);
            "r":       add_char(8'd13);
            "e":       add_char(CH_ESC);
            CH_QUOTE, CH_APOS, CH_BSLASH: add_char(b);
            CH_LF:     ;
            CH_CR:     scan_mode = MODE_CR;
            default:   raise_error();
         endcase
      end
   endtask

   task automatic close_octal();
      logic [8:0] v;
      v           = oct_value;
      scan_mode   = MODE_NORMAL;
      oct_value   = 9'd0;
      oct_stopped = 1'b0;
      oct_digits  = 2'd0;
      if (v > OCTAL_MAX) raise_error();
      else add_char(v[7:0]);
   endtask

   // digits 8 and 9 count but freeze the value; a non-digit closes the escape
   task automatic octal_byte(input logic [7:0] b);
      if (b >= CH_DIGIT0 && b <= CH_DIGIT9) begin
         if (!oct_stopped && b <= CH_DIGIT7) oct_value = (oct_value << 3) + 9'(b - CH_DIGIT0);
         else oct_stopped = 1'b1;
         oct_digits = oct_digits + 2'd1;
         if (oct_digits == 2'd3) close_octal();
      end else begin
         close_octal();
         if (step_words[$].kind != KIND_ERROR) plain_byte(b);
      end
   endtask

   task automatic predict_byte(input logic [7:0] b);
      result_type w;
      step_words = {};
      case (scan_mode)
         MODE_ESCAPE: escape_byte(b);
         MODE_OCTAL:  octal_byte(b);
         MODE_CR: begin
            scan_mode = MODE_NORMAL;
            if (b != CH_LF) plain_byte(b);
         end
         default: begin
            scan_mode = MODE_NORMAL;
            plain_byte(b);
         end
      endcase
      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.last = 1'b1;
         step_words.push_back(w);
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [11:0] want,
                              input logic [11:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         failures++;
      end
   endtask

   // accepted source bytes feed the predictor, accepted words are checked
   always @(posedge clock) begin
      result_type want;
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         predict_byte(req_in_byte);
         bytes_accepted++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, got kind %0h byte %0h len %0h last %0h",
                     $time, rsp_kind, rsp_out_byte, rsp_length, rsp_last);
            failures++;
         end else begin
            want = expected_words.pop_front();
            check_field("kind", 12'(want.kind), 12'(rsp_kind));
            check_field("out_byte", 12'(want.data), 12'(rsp_out_byte));
            check_field("length", want.length, rsp_length);
            check_field("last", 12'(want.last), 12'(rsp_last));
         end
      end
   end

   // ---------------------------------------------------------------- driver

   // a new byte goes out only once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left == 0 && idle_enable && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 14);
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_valid   <= 1'b1;
            req_in_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off to back up the block
   always @(negedge clock) begin
      if (hold_wanted && !hold_taken) begin
         hold_taken = 1'b1;
         stall_left = 300;
      end else if (stall_left == 0 && idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
      queue_byte(b);
   endtask

   // one string built from random tokens, mostly well formed
   task automatic queue_string(input int tokens, input bit closed);
      logic [7:0] letters[11] = '{"a", "b", "t", "n", "v", "f", "r", "e",
                                  CH_QUOTE, CH_APOS, CH_BSLASH};
      int pick;
      int nd;
      for (int i = 0; i < tokens; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            queue_plain();
         end else if (pick < 65) begin
            queue_byte(CH_BSLASH);
            queue_byte(letters[$urandom_range(0, 10)]);
         end else if (pick < 72) begin
            // line continuation: LF, CR or CR LF
            queue_byte(CH_BSLASH);
            nd = $urandom_range(0, 2);
            queue_byte(nd == 0 ? CH_LF : CH_CR);
            if (nd == 2) queue_byte(CH_LF);
         end else if (pick < 92) begin
            queue_byte(CH_BSLASH);
            nd = $urandom_range(1, 3);
            for (int d = 0; d < nd; d++)
               queue_byte(CH_DIGIT0 + 8'($urandom_range(0, 5) == 0 ? $urandom_range(8, 9)
                                                                   : $urandom_range(0, 7)));
         end else if (pick < 97) begin
            queue_byte(CH_BSLASH);
            queue_byte(8'($urandom_range(0, 255)));
         end else begin
            queue_byte($urandom_range(0, 1) ? CH_NUL : CH_QUOTE);
         end
      end
      if (closed) queue_byte(CH_QUOTE);
   endtask

   task automatic queue_strings(input int budget, input int max_tokens);
      int stop_at;
      stop_at = bytes_queued + budget;
      while (bytes_queued < stop_at)
         queue_string($urandom_range(1, max_tokens), $urandom_range(0, 9) != 0);
   endtask

   // idle means every byte taken and every word seen, followed by slack
   task automatic wait_drained();
      while (bytes_accepted != bytes_queued || expected_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_max_length(input logic [11:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      length_limit = value;
   endtask

   initial begin
      logic [7:0] directed_bytes[30] = '{
         "A", 8'hFF, CH_BSLASH, "e", CH_BSLASH, CH_CR, CH_LF, CH_BSLASH, CH_CR, "B",
         CH_BSLASH, CH_LF, CH_BSLASH, "1", "0", "1", CH_BSLASH, "3", "7", "7",
         CH_BSLASH, "7", CH_QUOTE, CH_BSLASH, "4", "0", "0", CH_BSLASH, "9", CH_NUL};
      int mark;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      idle_enable <= 1'b1;

      // directed: extremes, escapes, continuations, octal corner cases
      foreach (directed_bytes[i]) queue_byte(directed_bytes[i]);
      wait_drained();

      // short limits make over-length errors common
      write_max_length(12'd5);
      queue_strings(150, 10);
      wait_drained();

      idle_enable <= 1'b0;
      write_max_length(12'd1);
      queue_strings(100, 4);
      wait_drained();

      // bulk traffic at the default limit, with one long receiver hold-off
      idle_enable <= 1'b1;
      write_max_length(DEFAULT_MAX_LENGTH);
      mark = bytes_accepted + 100;
      queue_strings(650, 20);
      while (bytes_accepted < mark) @(negedge clock);
      hold_wanted <= 1'b1;
      wait_drained();

      // widest limit, no idling: random strings
      idle_enable <= 1'b0;
      write_max_length(12'd4095);
      queue_strings(250, 20);
      wait_drained();

      if (failures == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

endmodule
